@@ design/stpd_pkg.sv @@
package stpd_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int COORD_WIDTH = 16;
  localparam int DW = COORD_WIDTH + 1 + 24 + 2;
  localparam int QDEPTH = 4;
  localparam logic [15:0] TOP_DUTY_RST = 16'd49152;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef logic signed [DW-1:0] vec_t;

  function automatic logic [31:0] atan_tab(input int i);
    logic [31:0] r;
    unique case (i)
      0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
      3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
      6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
      9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
      12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
      15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
      18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
      21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    vec_t        x;
    vec_t        y;
    logic [31:0] z;
    logic [15:0] head;
  } pose_t;
endpackage

@@ design/stpd_if.sv @@
interface stpd_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic signed [15:0] cur_heading;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  modport source (output valid, cur_x, cur_y, cur_heading, target_x, target_y, input ready);
  modport sink (input valid, cur_x, cur_y, cur_heading, target_x, target_y, output ready);
endinterface

interface stpd_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] heading_error;
  logic [15:0] left_duty;
  logic [15:0] right_duty;
  modport source (output valid, heading_error, left_duty, right_duty, input ready);
  modport sink (input valid, heading_error, left_duty, right_duty, output ready);
endinterface

interface stpd_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ design/stpd_front.sv @@
// Forms dx/dy, prescales, folds into right half plane; the output is registered.
module stpd_front (
  input  logic clk,
  input  logic rst_n,
  stpd_in_if.sink in_ch,
  input  logic stall,
  output logic v_o,
  output stpd_pkg::pose_t p_o
);
  import stpd_pkg::*;
  logic signed [COORD_WIDTH-1:0] cx, cy, tx, ty;
  vec_t dx, dy;
  pose_t p_nxt, p_r;
  logic v_r;

  always_comb begin
    cx = COORD_WIDTH'(in_ch.cur_x);
    cy = COORD_WIDTH'(in_ch.cur_y);
    tx = COORD_WIDTH'(in_ch.target_x);
    ty = COORD_WIDTH'(in_ch.target_y);
    if (COORD_WIDTH > 16) begin
      cx = COORD_WIDTH'($unsigned(in_ch.cur_x));
      cy = COORD_WIDTH'($unsigned(in_ch.cur_y));
      tx = COORD_WIDTH'($unsigned(in_ch.target_x));
      ty = COORD_WIDTH'($unsigned(in_ch.target_y));
    end
    dx = (DW'(tx) - DW'(cx)) <<< 24;
    dy = (DW'(ty) - DW'(cy)) <<< 24;
    p_nxt.head = in_ch.cur_heading;
    p_nxt.x = dx;
    p_nxt.y = dy;
    p_nxt.z = '0;
    if (dx < 0) begin
      if (dy >= 0) begin
        p_nxt.x = dy; p_nxt.y = -dx; p_nxt.z = QUARTER_TURN;
      end else begin
        p_nxt.x = -dy; p_nxt.y = dx; p_nxt.z = -QUARTER_TURN;
      end
    end
  end

  assign in_ch.ready = !stall;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (!stall) v_r <= in_ch.valid;
    if (!stall) p_r <= p_nxt;
  end
  assign v_o = v_r;
  assign p_o = p_r;
endmodule

@@ design/stpd_queue.sv @@
module stpd_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  stpd_pkg::pose_t wd,
  output logic almost_full,
  input  logic rd,
  output logic nonempty,
  output stpd_pkg::pose_t rdat
);
  import stpd_pkg::*;
  localparam int AW = $clog2(QDEPTH);
  pose_t mem [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem[wp_r] <= wd;
  end
  assign rdat = mem[rp_r];
  assign nonempty = cnt_r != 0;
  // front holds one in flight, so stop one early
  assign almost_full = cnt_r >= (AW+1)'(QDEPTH - 1);
endmodule

@@ design/stpd_back.sv @@
// CORDIC pipeline, one step per stage, then a combinational mixer feeding the output register.
module stpd_back (
  input  logic clk,
  input  logic rst_n,
  input  logic v_i,
  input  stpd_pkg::pose_t p_i,
  output logic take,
  input  logic [15:0] top_duty,
  stpd_out_if.source out_ch
);
  import stpd_pkg::*;
  localparam int N = CORDIC_STEPS > 24 ? 24 : CORDIC_STEPS;
  pose_t st_r [N+1];
  logic  sv_r [N+1];
  logic  adv;
  logic  [31:0] err32;
  logic  [15:0] e16;
  logic  signed [17:0] fl, fr;
  logic  signed [18:0] k;
  logic  signed [17:0] mn;
  logic  signed [15:0] he_r;
  logic  [15:0] ld_r, rd_r;
  logic  ov_r;

  function automatic logic [15:0] duty(input logic signed [17:0] mnv,
                                       input logic signed [18:0] kv,
                                       input logic signed [17:0] f);
    logic signed [40:0] num;
    num = 41'(mnv) * 41'sd32768 + 41'(kv) * 41'(f) + 41'sd16384;
    if (num < 0) num = '0;
    num = num >>> 15;
    return (num > 41'sd65535) ? 16'hFFFF : num[15:0];
  endfunction

  assign adv = !ov_r || out_ch.ready;
  assign take = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) sv_r[i] <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= v_i;
      for (int i = 1; i <= N; i++) sv_r[i] <= sv_r[i-1];
      ov_r <= sv_r[N];
    end
    if (adv) begin
      st_r[0] <= p_i;
      for (int i = 0; i < N; i++) begin
        st_r[i+1].head <= st_r[i].head;
        if (st_r[i].x == 0 && st_r[i].y == 0) begin
          st_r[i+1].x <= st_r[i].x;
          st_r[i+1].y <= st_r[i].y;
          st_r[i+1].z <= st_r[i].z;
        end else if (st_r[i].y >= 0) begin
          st_r[i+1].x <= st_r[i].x + (st_r[i].y >>> i);
          st_r[i+1].y <= st_r[i].y - (st_r[i].x >>> i);
          st_r[i+1].z <= st_r[i].z + atan_tab(i);
        end else begin
          st_r[i+1].x <= st_r[i].x - (st_r[i].y >>> i);
          st_r[i+1].y <= st_r[i].y + (st_r[i].x >>> i);
          st_r[i+1].z <= st_r[i].z - atan_tab(i);
        end
      end
      he_r <= e16;
      ld_r <= duty(mn, k, fl);
      rd_r <= duty(mn, k, fr);
    end
  end

  always_comb begin
    err32 = QUARTER_TURN - st_r[N].z - {st_r[N].head, 16'h0};
    e16 = 16'((err32 + 32'h8000) >> 16);
    fl = 18'sd32768; fr = 18'sd32768;
    if ($signed(e16) > 0) fr = 18'sd32768 - 18'($signed(e16));
    else fl = 18'sd32768 + 18'($signed(e16));
    mn = 18'sd65536 - 18'($unsigned(top_duty));
    k = 19'($unsigned(top_duty)) * 19'sd2 - 19'sd65536;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.heading_error = he_r;
  assign out_ch.left_duty = ld_r;
  assign out_ch.right_duty = rd_r;
endmodule

@@ design/steer_to_point_differential_duty.sv @@
// Result path: input stage register, queue, CORDIC stages, output register.
// Throughput: one transaction per cycle while out_ch is ready and the queue
// is not almost full; the CORDIC pipeline runs one micro-rotation per stage
// and advances whenever the output register frees.
// A four-entry queue separates the input stage from the CORDIC pipeline.
// Reset (rst_n low, synchronous) empties all stages; top duty returns to 49152.
module steer_to_point_differential_duty (
  input  logic clk,
  input  logic rst_n,
  stpd_in_if.sink in_ch,
  stpd_cfg_if.sink cfg_ch,
  stpd_out_if.source out_ch
);
  import stpd_pkg::*;
  logic [15:0] top_duty_r;
  logic fv, afull, ne, take;
  pose_t fp, qd;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) top_duty_r <= TOP_DUTY_RST;
    else if (cfg_ch.valid) top_duty_r <= cfg_ch.data;
  end

  stpd_front u_front (.clk, .rst_n, .in_ch, .stall(afull), .v_o(fv), .p_o(fp));
  stpd_queue u_q (.clk, .rst_n, .wr(fv && !afull), .wd(fp), .almost_full(afull),
                  .rd(ne && take), .nonempty(ne), .rdat(qd));
  stpd_back u_back (.clk, .rst_n, .v_i(ne), .p_i(qd), .take, .top_duty(top_duty_r),
                    .out_ch);
endmodule
